// ----- src/bnlsky_pkg.sv -----
// Shared types, codes and helpers for the skyline window block.
// No dependencies; the top, datapath and controller in src import this package.
package bnlsky_pkg;

    // Operation requested by an input beat
    typedef enum logic [1:0] {
        FN_OFFER = 2'd0,
        FN_READ  = 2'd1,
        FN_CLEAR = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    // Result status codes
    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_DOMINATED = 3'd1,
        ST_ZERO_SKIP = 3'd2,
        ST_FULL      = 3'd3,
        ST_ENTRY     = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_CLEARED   = 3'd6
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RD_ISSUE,
        S_RD_DATA,
        S_FINISH
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load_in;   // latch point, rewind scan pointers
        logic    zero_inc;  // count a skipped all-zero point
        logic    clear;     // empty window and zero counter
        logic    rd_issue;  // read window entry at the read pointer
        logic    cmp_en;    // compare the entry read last cycle
        logic    resolve;   // commit compaction result
        logic    append;    // store the offered point after the kept entries
        logic    out_load;  // load the output register
        logic    out_entry; // result carries the entry just read
        logic    out_last;  // last flag for an entry result
        t_status out_status;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic zero_skip;  // input point is all zero and skipping is on
        logic dominated;  // entry just read is <= offered point everywhere
        logic cmp_vld;    // read data is pending comparison
        logic rd_done;    // read pointer reached the window count
        logic kept_full;  // kept entries fill the window
        logic count_zero; // window is empty
        logic out_free;   // output register can take a result
    } t_stat;

    // True if a is less than or equal to b in every 8-bit coordinate
    function automatic logic all_le(input logic [63:0] a, input logic [63:0] b);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (a[8*i +: 8] > b[8*i +: 8]) ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

// ----- src/bnl_skyline_window_top.sv -----
// Top level of the skyline window block: controller plus datapath.
// Depends on bnlsky_pkg, bnlsky_ctrl, bnlsky_dp (which holds bnlsky_ram).
//
// Keeps up to WINDOW mutually non-dominated points (smaller is better) in a
// RAM with one write port and one registered read port, and works on one
// input beat at a time. An offered point is compared against the window one
// entry per cycle through the RAM read port, with survivors compacted in
// place on the write port. Its result is loaded once the output register is
// free, and the controller then returns to idle to take the next beat; the
// scan ends early when an entry dominates the point. A readout reads each
// entry from RAM, then loads it into the output register once that is free;
// a clear or skipped zero point loads its result the same way. Results sit in
// an output register, so a new beat is accepted while the last result still
// waits. skip_zero is written through i_cfg_we / i_cfg_wdata and resets to 1.
// Window RAM contents are undefined after reset; the window count alone says
// which entries are live.
module bnl_skyline_window_top #(
    parameter int WINDOW = 64,
    parameter int DIMS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_point,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [63:0] o_entry_point,
    output logic        o_entry_last,
    output logic [6:0]  o_skyline_count,
    output logic [6:0]  o_removed_count,
    output logic [15:0] o_zero_total
);
    import bnlsky_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bnlsky_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_func),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bnlsky_dp #(
        .WINDOW (WINDOW),
        .DIMS   (DIMS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_point         (i_point),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_entry_point   (o_entry_point),
        .o_entry_last    (o_entry_last),
        .o_skyline_count (o_skyline_count),
        .o_removed_count (o_removed_count),
        .o_zero_total    (o_zero_total)
    );

endmodule

// ----- src/bnlsky_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bnlsky_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/bnlsky_dp.sv -----
// Datapath of the skyline window: window RAM, scan pointers, counters,
// config register and output register. Depends on bnlsky_pkg, bnlsky_ram.
module bnlsky_dp #(
    parameter int WINDOW = 64,
    parameter int DIMS   = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bnlsky_pkg::t_cmd    i_cmd,
    output bnlsky_pkg::t_stat   o_stat,
    input  logic [63:0]         i_point,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [2:0]          o_status,
    output logic [63:0]         o_entry_point,
    output logic                o_entry_last,
    output logic [6:0]          o_skyline_count,
    output logic [6:0]          o_removed_count,
    output logic [15:0]         o_zero_total
);
    import bnlsky_pkg::*;

    localparam int AW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    localparam int PB = 8 * DIMS;
    localparam logic [63:0] MASK = (PB >= 64) ? {64{1'b1}} : ((64'd1 << PB) - 64'd1);
    localparam logic [CW-1:0] WIN_C = CW'(WINDOW);

    logic [63:0]   r_pt;
    logic [CW-1:0] r_rd_idx;
    logic [CW-1:0] r_kept;
    logic          r_cmp_vld;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_removed;
    logic [15:0]   r_zero;
    logic          r_skip;

    logic          r_out_vld;
    logic [2:0]    r_o_status;
    logic [63:0]   r_o_entry;
    logic          r_o_last;
    logic [6:0]    r_o_sky;
    logic [6:0]    r_o_rem;
    logic [15:0]   r_o_zero;

    logic [63:0]   ram_rdata;
    logic          ram_we;
    logic [63:0]   ram_wdata;
    logic          pt_beats;
    logic          ent_dom;

    // Dominance tests between the offered point and the entry read
    assign ent_dom  = all_le(ram_rdata, r_pt);
    assign pt_beats = all_le(r_pt, ram_rdata);

    // Compaction writes surviving entries down to the kept pointer
    assign ram_we    = (i_cmd.cmp_en && !pt_beats) || i_cmd.append;
    assign ram_wdata = i_cmd.append ? r_pt : ram_rdata;

    bnlsky_ram #(
        .WIDTH (64),
        .DEPTH (WINDOW)
    ) u_win (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_kept[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Status toward the controller
    always_comb begin
        o_stat.zero_skip  = r_skip && ((i_point & MASK) == 64'd0);
        o_stat.dominated  = r_cmp_vld && ent_dom;
        o_stat.cmp_vld    = r_cmp_vld;
        o_stat.rd_done    = (r_rd_idx == r_count);
        o_stat.kept_full  = (r_kept == WIN_C);
        o_stat.count_zero = (r_count == '0);
        o_stat.out_free   = !r_out_vld || i_out_ready;
    end

    // Latch point and advance scan pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pt <= i_point & MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_kept    <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.load_in) begin
            r_rd_idx  <= '0;
            r_kept    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.rd_issue;
            if (i_cmd.rd_issue) r_rd_idx <= r_rd_idx + 1'b1;
            if (i_cmd.cmp_en && !pt_beats) r_kept <= r_kept + 1'b1;
        end
    end

    // Window count and removed count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_removed <= '0;
        end else if (i_cmd.clear) begin
            r_count   <= '0;
            r_removed <= '0;
        end else if (i_cmd.load_in) begin
            r_removed <= '0;
        end else if (i_cmd.resolve) begin
            r_removed <= r_count - r_kept;
            r_count   <= i_cmd.append ? r_kept + 1'b1 : r_kept;
        end
    end

    // Saturating zero-point counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero <= '0;
        end else if (i_cmd.clear) begin
            r_zero <= '0;
        end else if (i_cmd.zero_inc && r_zero != 16'hFFFF) begin
            r_zero <= r_zero + 16'd1;
        end
    end

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 1'b1;
        end else if (i_cfg_we) begin
            r_skip <= i_cfg_wdata;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status <= i_cmd.out_status;
            r_o_entry  <= i_cmd.out_entry ? ram_rdata : 64'd0;
            r_o_last   <= i_cmd.out_entry ? i_cmd.out_last : 1'b1;
            r_o_sky    <= 7'(r_count);
            r_o_rem    <= 7'(r_removed);
            r_o_zero   <= r_zero;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_o_status;
    assign o_entry_point   = r_o_entry;
    assign o_entry_last    = r_o_last;
    assign o_skyline_count = r_o_sky;
    assign o_removed_count = r_o_rem;
    assign o_zero_total    = r_o_zero;

endmodule

// ----- src/bnlsky_ctrl.sv -----
// Controller state machine of the skyline window: sequences offer scans,
// readout and result delivery. Depends on bnlsky_pkg.
module bnlsky_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_func,
    input  bnlsky_pkg::t_stat i_stat,
    output bnlsky_pkg::t_cmd  o_cmd
);
    import bnlsky_pkg::*;

    t_state  r_state, n_state;
    t_status r_res, n_res;
    t_func   func;
    logic    acc;

    assign func       = t_func'(i_func);
    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid && (r_state == S_IDLE);

    // State and pending result code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res   <= ST_ADDED;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        o_cmd   = '0;
        o_cmd.out_status = r_res;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (func)
                        FN_OFFER: begin
                            o_cmd.load_in = 1'b1;
                            if (i_stat.zero_skip) begin
                                o_cmd.zero_inc = 1'b1;
                                n_res   = ST_ZERO_SKIP;
                                n_state = S_FINISH;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        FN_READ: begin
                            o_cmd.load_in = 1'b1;
                            if (i_stat.count_zero) begin
                                n_res   = ST_EMPTY;
                                n_state = S_FINISH;
                            end else begin
                                n_state = S_RD_ISSUE;
                            end
                        end
                        FN_CLEAR: begin
                            o_cmd.clear = 1'b1;
                            n_res   = ST_CLEARED;
                            n_state = S_FINISH;
                        end
                        default: begin
                            // unused code: drop the beat
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (i_stat.dominated) begin
                    // window is an antichain, so nothing was removed so far
                    n_res   = ST_DOMINATED;
                    n_state = S_FINISH;
                end else if (i_stat.rd_done && !i_stat.cmp_vld) begin
                    o_cmd.resolve = 1'b1;
                    if (i_stat.kept_full) begin
                        n_res = ST_FULL;
                    end else begin
                        o_cmd.append = 1'b1;
                        n_res = ST_ADDED;
                    end
                    n_state = S_FINISH;
                end else begin
                    o_cmd.rd_issue = !i_stat.rd_done;
                    o_cmd.cmp_en   = i_stat.cmp_vld;
                end
            end
            S_RD_ISSUE: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_entry  = 1'b1;
                    o_cmd.out_last   = i_stat.rd_done;
                    o_cmd.out_status = ST_ENTRY;
                    n_state = i_stat.rd_done ? S_IDLE : S_RD_ISSUE;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the skyline window block (bnl_skyline_window_top).
// Depends on bnlsky_pkg for the operation and status codes; predicts every
// result beat in its own window model and checks the beats in order.
`timescale 1ns / 1ps

module testbench;
    import bnlsky_pkg::*;

    localparam int WINDOW = 64;
    localparam int DIMS = 8;
    localparam logic [63:0] COORD_MASK = (DIMS >= 8) ? {64{1'b1}}
                                                     : ((64'd1 << (8 * DIMS)) - 64'd1);
    localparam int IDLE_LIMIT = 2000;
    localparam int CFG_SETTLE = 16;
    localparam int END_SETTLE = WINDOW + 8;

    // One expected result beat
    typedef struct {
        t_status     status;
        logic [63:0] entry;
        logic        last;
        logic [6:0]  count;
        logic [6:0]  removed;
        logic [15:0] zeros;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_func;
    logic [63:0] i_point;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [63:0] o_entry_point;
    logic        o_entry_last;
    logic [6:0]  o_skyline_count;
    logic [6:0]  o_removed_count;
    logic [15:0] o_zero_total;

    // Window model and its settings
    logic [63:0] model_window [WINDOW];
    int          model_count;
    logic [15:0] model_zeros;
    bit          model_skip_zero;

    t_outcome expected_outcomes[$];
    int       errors = 0;
    int       out_stall = 0;
    int       idle_cycles = 0;

    bnl_skyline_window_top #(
        .WINDOW(WINDOW),
        .DIMS  (DIMS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_point        (i_point),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_entry_point  (o_entry_point),
        .o_entry_last   (o_entry_last),
        .o_skyline_count(o_skyline_count),
        .o_removed_count(o_removed_count),
        .o_zero_total   (o_zero_total)
    );

    // 50 MHz clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // True if a is no worse than b in every coordinate
    function automatic bit no_worse(input logic [63:0] a, input logic [63:0] b);
        bit ok;
        ok = 1'b1;
        for (int k = 0; k < DIMS; k++) begin
            if (a[8*k +: 8] > b[8*k +: 8]) ok = 1'b0;
        end
        return ok;
    endfunction

    // Queue one result beat using the model's current counters
    function automatic void push_outcome(input t_status st, input logic [63:0] ent,
                                         input bit last, input int removed);
        t_outcome r;
        r.status  = st;
        r.entry   = ent;
        r.last    = last;
        r.count   = 7'(model_count);
        r.removed = 7'(removed);
        r.zeros   = model_zeros;
        expected_outcomes.insert(expected_outcomes.size(), r);
    endfunction

    // Advance the window model by one accepted beat and queue its results
    function automatic void predict_skyline(input logic [1:0] fn, input logic [63:0] raw);
        logic [63:0] p;
        bit          beaten;
        int          kept;
        int          removed;
        p = raw & COORD_MASK;
        case (fn)
            FN_OFFER: begin
                if (model_skip_zero && p == 64'd0) begin
                    if (model_zeros != 16'hFFFF) model_zeros++;
                    push_outcome(ST_ZERO_SKIP, 64'd0, 1'b1, 0);
                end else begin
                    beaten = 1'b0;
                    for (int k = 0; k < model_count; k++) begin
                        if (no_worse(model_window[k], p)) beaten = 1'b1;
                    end
                    if (beaten) begin
                        push_outcome(ST_DOMINATED, 64'd0, 1'b1, 0);
                    end else begin
                        // drop entries the point covers, compact the rest in order
                        kept = 0;
                        for (int k = 0; k < model_count; k++) begin
                            if (!no_worse(p, model_window[k])) begin
                                model_window[kept] = model_window[k];
                                kept++;
                            end
                        end
                        removed = model_count - kept;
                        model_count = kept;
                        if (model_count >= WINDOW) begin
                            push_outcome(ST_FULL, 64'd0, 1'b1, removed);
                        end else begin
                            model_window[model_count] = p;
                            model_count++;
                            push_outcome(ST_ADDED, 64'd0, 1'b1, removed);
                        end
                    end
                end
            end
            FN_READ: begin
                if (model_count == 0) begin
                    push_outcome(ST_EMPTY, 64'd0, 1'b1, 0);
                end else begin
                    for (int k = 0; k < model_count; k++)
                        push_outcome(ST_ENTRY, model_window[k], k == model_count - 1, 0);
                end
            end
            FN_CLEAR: begin
                model_count = 0;
                model_zeros = 16'd0;
                push_outcome(ST_CLEARED, 64'd0, 1'b1, 0);
            end
            default: begin
            end
        endcase
    endfunction

    // Send one input beat after a random gap; returns at the accepting edge
    task automatic send_beat(input logic [1:0] fn, input logic [63:0] pt);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= fn;
        i_point    <= pt;
        do @(posedge i_clk); while (!o_in_ready);
        predict_skyline(fn, pt);
    endtask

    // Drop valid, wait for every expected beat, then let the block settle
    task automatic wait_idle(input int settle);
        i_in_valid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_skip_zero(input bit value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        model_skip_zero = value;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] draw_point();
        logic [63:0] pt;
        case ($urandom_range(0, 3))
            0, 1: for (int k = 0; k < 8; k++) pt[8*k +: 8] = 8'($urandom_range(0, 3));
            2: pt = {$urandom, $urandom};
            default: for (int k = 0; k < 8; k++) pt[8*k +: 8] = 8'($urandom_range(0, 15));
        endcase
        return pt;
    endfunction

    // Readout, clear and the unused code on an empty window
    task automatic test_empty_window();
        send_beat(FN_READ, 64'd0);
        send_beat(FN_NONE, {64{1'b1}});
        send_beat(FN_CLEAR, {64{1'b1}});
        send_beat(FN_READ, {64{1'b1}});
        wait_idle(CFG_SETTLE);
    endtask

    // Add, dominate, equal, incomparable, multi-removal and zero skip
    task automatic test_offer_rules();
        send_beat(FN_OFFER, {64{1'b1}});
        send_beat(FN_OFFER, 64'h0101_0101_0101_0101);
        send_beat(FN_OFFER, 64'h0101_0101_0101_0101);
        send_beat(FN_OFFER, 64'h0000_0000_0000_0002);
        send_beat(FN_OFFER, 64'h0000_0000_0000_0200);
        send_beat(FN_READ, 64'd0);
        send_beat(FN_OFFER, 64'h0000_0000_0000_0100);
        send_beat(FN_OFFER, 64'h8000_0000_0000_0000);
        send_beat(FN_OFFER, 64'd0);
        send_beat(FN_NONE, 64'h5A5A_A5A5_0F0F_F0F0);
        send_beat(FN_READ, 64'd0);
        send_beat(FN_CLEAR, 64'd0);
        send_beat(FN_READ, 64'd0);
        wait_idle(CFG_SETTLE);
    endtask

    // With skipping off a zero point is ordinary and beats everything
    task automatic test_zero_as_point();
        write_skip_zero(1'b0);
        send_beat(FN_OFFER, 64'h0302_0100_0706_0504);
        send_beat(FN_OFFER, 64'h0405_0607_0001_0203);
        send_beat(FN_OFFER, 64'd0);
        send_beat(FN_OFFER, 64'd0);
        send_beat(FN_READ, 64'd0);
        send_beat(FN_CLEAR, 64'd0);
        wait_idle(CFG_SETTLE);
        write_skip_zero(1'b1);
    endtask

    // Fill the window with incomparable points, overflow it, read it all,
    // then wipe it out with a single zero point
    task automatic test_full_window();
        logic [63:0] pt;
        send_beat(FN_CLEAR, 64'd0);
        for (int k = 0; k < WINDOW; k++) begin
            pt = 64'h8080_8080_8080_0000 | (64'(200 - k) << 8) | 64'(k);
            send_beat(FN_OFFER, pt);
        end
        send_beat(FN_OFFER, 64'h8080_8080_8080_3264);
        send_beat(FN_READ, 64'd0);
        wait_idle(CFG_SETTLE);
        write_skip_zero(1'b0);
        send_beat(FN_OFFER, 64'd0);
        send_beat(FN_READ, 64'd0);
        wait_idle(CFG_SETTLE);
        write_skip_zero(1'b1);
        send_beat(FN_CLEAR, 64'd0);
        wait_idle(CFG_SETTLE);
    endtask

    // Count skipped zero points, then clear the counter
    task automatic test_zero_counter();
        for (int k = 0; k < 3; k++) send_beat(FN_OFFER, 64'd0);
        send_beat(FN_CLEAR, 64'd0);
        send_beat(FN_OFFER, 64'd0);
        wait_idle(CFG_SETTLE);
    endtask

    // Random traffic in phases, skipping toggled between phases
    task automatic test_random_traffic();
        int sent;
        int pick;
        for (int phase = 0; phase < 4; phase++) begin
            write_skip_zero(phase[0]);
            sent = 0;
            while (sent < 17) begin
                pick = $urandom_range(0, 99);
                if (pick < 72) begin
                    send_beat(FN_OFFER, draw_point());
                    sent++;
                end else if (pick < 84) begin
                    send_beat(FN_READ, {$urandom, $urandom});
                    sent++;
                end else if (pick < 90) begin
                    send_beat(FN_CLEAR, {$urandom, $urandom});
                    sent++;
                end else if (pick < 96) begin
                    send_beat(FN_NONE, {$urandom, $urandom});
                end else begin
                    send_beat(FN_OFFER, 64'd0);
                    sent++;
                end
            end
            wait_idle(CFG_SETTLE);
        end
    endtask

    // Stall the result side at random
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) out_stall = $urandom_range(0, 9);
        if (out_stall > 0) begin
            i_out_ready <= 1'b0;
            out_stall--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result, actual status=%0d entry=%h last=%b",
                         $time, o_status, o_entry_point, o_entry_last);
                errors++;
            end else begin
                want = expected_outcomes.pop_front();
                if (o_status !== want.status || o_entry_point !== want.entry ||
                    o_entry_last !== want.last || o_skyline_count !== want.count ||
                    o_removed_count !== want.removed || o_zero_total !== want.zeros) begin
                    $display("%0t: mismatch expected st=%0d ent=%h last=%b cnt=%0d rm=%0d z=%0d",
                             $time, want.status, want.entry, want.last, want.count,
                             want.removed, want.zeros);
                    $display("%0t:          actual   st=%0d ent=%h last=%b cnt=%0d rm=%0d z=%0d",
                             $time, o_status, o_entry_point, o_entry_last, o_skyline_count,
                             o_removed_count, o_zero_total);
                    errors++;
                end
            end
        end
    end

    // End the run when no beat moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_func          = FN_OFFER;
        i_point         = 64'd0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = 1'b0;
        model_count     = 0;
        model_zeros     = 16'd0;
        model_skip_zero = 1'b1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_window();
        test_offer_rules();
        test_zero_as_point();
        test_full_window();
        test_zero_counter();
        test_random_traffic();

        wait_idle(END_SETTLE);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
